[rtl/ests_pkg.sv]
package ests_pkg;

  localparam int CHAR_W     = 8;
  localparam int VAL_W      = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int ITER_W     = $clog2(VAL_W);
  localparam int MAX_PLAIN  = 3;

  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h27;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_QMARK  = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [DIGIT_W-1:0] CH_DIGIT_HI = 4'h3;

  localparam logic [1:0] HELD_NONE   = 2'd0;
  localparam logic [1:0] HELD_BSL    = 2'd1;
  localparam logic [1:0] HELD_BSLDOL = 2'd2;
  localparam logic [1:0] HELD_DOL    = 2'd3;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [DIGIT_W-1:0] bcd_digit_t;
  typedef bcd_digit_t [NUM_DIGITS-1:0] bcd_word_t;

  typedef struct packed {
    logic             busy;
    logic             neg;
    logic [IDX_W-1:0] msd;
  } conv_stat_t;

endpackage

[rtl/ests_byte_if.sv]
interface ests_byte_if;
  import ests_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_code;
  logic  last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink (input valid, input char_code, input last, output ready);

endinterface

[rtl/exit_status_token_substituter.sv]
// Rewrites a byte string and replaces each "$?" outside single quotes with the
// signed decimal text of the last cfg_wdata value; "\$?" yields a literal "$?"
// and quoted text passes unchanged. A request is taken only when the block is
// idle; it produces up to three plain bytes, or up to eleven for a
// substitution, each sent when out_s.ready allows. Writing cfg_wdata starts a
// shift-and-adjust binary to decimal conversion in a single shared unit,
// during which in_s.ready is low.
module exit_status_token_substituter
  import ests_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  ests_byte_if.sink               in_s,
  ests_byte_if.source             out_s,
  input  logic                    cfg_we,
  input  logic signed [VAL_W-1:0] cfg_wdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  conv_stat_t conv;
  bcd_word_t  digits;

  ests_bcd u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cfg_we),
    .value  (cfg_wdata),
    .stat   (conv),
    .digits (digits)
  );

  logic             state_r, state_nxt;
  logic             quote_r, quote_nxt;
  logic [1:0]       held_r, held_nxt;
  char_t            buf_r [MAX_PLAIN];
  char_t            buf_nxt [MAX_PLAIN];
  logic [1:0]       cnt_r, cnt_nxt;
  logic [1:0]       pos_r;
  logic             dig_r, dig_nxt;
  logic             last_r;
  logic             sign_r;
  logic [IDX_W-1:0] idx_r;
  logic             out_valid_r;
  char_t            out_char_r;
  logic             out_last_r;

  logic       in_ready, accept, out_load;
  char_t      c;
  logic       fr_push, fr_quote;
  logic [1:0] fr_held;
  char_t      emit_char;
  logic       emit_final;

  assign in_ready = (state_r == ST_IDLE) && !conv.busy && !cfg_we;
  assign accept   = in_s.valid && in_ready;
  assign out_load = !out_valid_r || out_s.ready;
  assign c        = in_s.char_code;

  assign fr_push  = (c != CH_BSLASH) && (c != CH_DOLLAR);
  assign fr_quote = (c == CH_QUOTE);
  assign fr_held  = (c == CH_BSLASH) ? HELD_BSL : ((c == CH_DOLLAR) ? HELD_DOL : HELD_NONE);

  always_comb begin
    quote_nxt = quote_r;
    held_nxt  = held_r;
    dig_nxt   = 1'b0;
    cnt_nxt   = '0;
    for (int i = 0; i < MAX_PLAIN; i++) begin
      buf_nxt[i] = c;
    end
    if (quote_r) begin
      buf_nxt[0] = c;
      cnt_nxt    = 2'd1;
      if (c == CH_QUOTE) begin
        quote_nxt = 1'b0;
      end
    end else begin
      unique case (held_r)
        HELD_NONE: begin
          if (fr_push) begin
            buf_nxt[0] = c;
            cnt_nxt    = 2'd1;
          end
          quote_nxt = fr_quote;
          held_nxt  = fr_held;
        end
        HELD_BSL: begin
          if (c == CH_DOLLAR) begin
            held_nxt = HELD_BSLDOL;
          end else begin
            buf_nxt[0] = CH_BSLASH;
            cnt_nxt    = 2'd1;
            if (fr_push) begin
              buf_nxt[1] = c;
              cnt_nxt    = 2'd2;
            end
            quote_nxt = fr_quote;
            held_nxt  = fr_held;
          end
        end
        HELD_BSLDOL: begin
          if (c == CH_QMARK) begin
            buf_nxt[0] = CH_DOLLAR;
            buf_nxt[1] = CH_QMARK;
            cnt_nxt    = 2'd2;
            held_nxt   = HELD_NONE;
          end else begin
            buf_nxt[0] = CH_BSLASH;
            buf_nxt[1] = CH_DOLLAR;
            cnt_nxt    = 2'd2;
            if (fr_push) begin
              buf_nxt[2] = c;
              cnt_nxt    = 2'd3;
            end
            quote_nxt = fr_quote;
            held_nxt  = fr_held;
          end
        end
        default: begin
          if (c == CH_QMARK) begin
            dig_nxt  = 1'b1;
            held_nxt = HELD_NONE;
          end else begin
            buf_nxt[0] = CH_DOLLAR;
            cnt_nxt    = 2'd1;
            if (fr_push) begin
              buf_nxt[1] = c;
              cnt_nxt    = 2'd2;
            end
            quote_nxt = fr_quote;
            held_nxt  = fr_held;
          end
        end
      endcase
    end
    if (in_s.last) begin
      unique case (held_nxt)
        HELD_BSL: begin
          buf_nxt[cnt_nxt] = CH_BSLASH;
          cnt_nxt          = cnt_nxt + 2'd1;
        end
        HELD_BSLDOL: begin
          buf_nxt[cnt_nxt] = CH_BSLASH;
          cnt_nxt          = cnt_nxt + 2'd1;
          buf_nxt[cnt_nxt] = CH_DOLLAR;
          cnt_nxt          = cnt_nxt + 2'd1;
        end
        HELD_DOL: begin
          buf_nxt[cnt_nxt] = CH_DOLLAR;
          cnt_nxt          = cnt_nxt + 2'd1;
        end
        default: begin
        end
      endcase
      held_nxt  = HELD_NONE;
      quote_nxt = 1'b0;
    end
  end

  always_comb begin
    emit_char  = buf_r[pos_r];
    emit_final = (pos_r == cnt_r - 2'd1);
    if (dig_r) begin
      if (sign_r) begin
        emit_char  = CH_MINUS;
        emit_final = 1'b0;
      end else begin
        emit_char  = {CH_DIGIT_HI, digits[idx_r]};
        emit_final = (idx_r == '0);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (dig_nxt || cnt_nxt != '0)) begin
          state_nxt = ST_EMIT;
        end
      end
      default: begin
        if (out_load && emit_final) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      quote_r     <= 1'b0;
      held_r      <= HELD_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        quote_r <= quote_nxt;
        held_r  <= held_nxt;
      end
      if (state_r == ST_EMIT && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_r  <= buf_nxt;
      cnt_r  <= cnt_nxt;
      dig_r  <= dig_nxt;
      last_r <= in_s.last;
      pos_r  <= '0;
      sign_r <= conv.neg;
      idx_r  <= conv.msd;
    end else if (state_r == ST_EMIT && out_load) begin
      out_char_r <= emit_char;
      out_last_r <= emit_final && last_r;
      if (!dig_r) begin
        pos_r <= pos_r + 2'd1;
      end else if (sign_r) begin
        sign_r <= 1'b0;
      end else begin
        idx_r <= idx_r - 1'b1;
      end
    end
  end

  assign in_s.ready      = in_ready;
  assign out_s.valid     = out_valid_r;
  assign out_s.char_code = out_char_r;
  assign out_s.last      = out_last_r;

endmodule

[rtl/ests_bcd.sv]
module ests_bcd
  import ests_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [VAL_W-1:0] value,
  output conv_stat_t              stat,
  output bcd_word_t               digits
);

  bcd_word_t         bcd_r, bcd_nxt, adj;
  logic [VAL_W-1:0]  mag_r, mag_nxt;
  logic              neg_r;
  logic              busy_r;
  logic [ITER_W-1:0] iter_r;
  logic [DIGIT_W*NUM_DIGITS+VAL_W-1:0] sh;
  logic [IDX_W-1:0]  msd;

  always_comb begin
    adj = bcd_r;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i] >= 4'd5) begin
        adj[i] = bcd_r[i] + 4'd3;
      end
    end
    sh = {adj, mag_r} << 1;
    bcd_nxt = sh[DIGIT_W*NUM_DIGITS+VAL_W-1:VAL_W];
    mag_nxt = sh[VAL_W-1:0];
  end

  always_comb begin
    msd = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i] != '0) begin
        msd = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcd_r  <= '0;
      mag_r  <= '0;
      neg_r  <= 1'b0;
      busy_r <= 1'b0;
      iter_r <= '0;
    end else if (start) begin
      bcd_r  <= '0;
      neg_r  <= value[VAL_W-1];
      mag_r  <= value[VAL_W-1] ? (~value + 1'b1) : value;
      busy_r <= 1'b1;
      iter_r <= '0;
    end else if (busy_r) begin
      bcd_r  <= bcd_nxt;
      mag_r  <= mag_nxt;
      iter_r <= iter_r + 1'b1;
      if (iter_r == ITER_W'(VAL_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.neg  = neg_r;
  assign stat.msd  = msd;
  assign digits    = bcd_r;

endmodule
